@@ rtl/pidf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidf_pkg: shared types and constants of the PID step block
// Field widths, register map, reset values and the multiply-accumulate command.
// ----------------------------------------------------------------------------
package pidf_pkg;

    // process values Q7.8, error one bit wider, derivative one more
    localparam int PV_W     = 16;
    localparam int ERR_W    = 17;
    localparam int DER_W    = 18;
    localparam int GAIN_W   = 24;
    localparam int SUM_W    = 32;
    localparam int LIM_W    = 31;
    localparam int ALPHA_W  = 9;
    localparam int ALPHAS_W = 18;
    localparam int STEP_W   = 18;

    // shared multiplier: 24 x 32 signed, accumulated at 58 bits
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 58;
    localparam int DRV_W   = ACC_W - 12;

    // APB register port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_MIN = 9'd3;
    localparam logic [ALPHA_W:0]   ALPHA_ONE = 10'd256;
    localparam logic [12:0]        TENTH_Q15 = 13'd3277;

    localparam logic [ACC_W-1:0] BIAS_EMA = 58'd128;
    localparam logic [ACC_W-1:0] BIAS_INT = 58'd16384;
    localparam logic [ACC_W-1:0] BIAS_DRV = 58'd2048;

    localparam logic [PV_W-1:0]     RST_OUT_MAX = 16'd25600;
    localparam logic [LIM_W-1:0]    RST_WINDUP  = 31'd20480;
    localparam logic [ALPHAS_W-1:0] RST_ALPHAS  = 18'd131328;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_HOLD   = 1'b1;

    typedef enum logic [2:0] {
        REG_SETPOINT,
        REG_PROP_GAIN,
        REG_INTEGRAL_GAIN,
        REG_DERIVATIVE_GAIN,
        REG_OUT_MIN,
        REG_OUT_MAX,
        REG_WINDUP_LIMIT,
        REG_FILTER_ALPHAS
    } t_reg_idx;

    typedef struct packed {
        logic signed [PV_W-1:0]   setpoint;
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integral_gain;
        logic signed [GAIN_W-1:0] derivative_gain;
        logic signed [PV_W-1:0]   out_min;
        logic signed [PV_W-1:0]   out_max;
        logic [LIM_W-1:0]         windup_limit;
        logic [ALPHAS_W-1:0]      filter_alphas;
    } t_cfg;

    typedef struct packed {
        logic                      en;
        logic                      first;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
        logic [ACC_W-1:0]          bias;
    } t_mac_cmd;

endpackage

@@ rtl/pidf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidf_in_if: sample item channel
// Valid/ready channel carrying the operation code and one measurement.
// ----------------------------------------------------------------------------
interface pidf_in_if import pidf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [PV_W-1:0]      measured_value;

    modport source (output valid, output operation, output measured_value, input ready);
    modport sink   (input valid, input operation, input measured_value, output ready);
endinterface

@@ rtl/pidf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidf_out_if: result item channel
// Valid/ready channel carrying drive, error and the windup flag.
// ----------------------------------------------------------------------------
interface pidf_out_if import pidf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PV_W-1:0]      drive;
    logic [ERR_W-1:0]     error_value;
    logic                 integral_limited;

    modport source (output valid, output drive, output error_value,
                    output integral_limited, input ready);
    modport sink   (input valid, input drive, input error_value,
                    input integral_limited, output ready);
endinterface

@@ rtl/pidf_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidf_cfg_regs: APB register file
// Eight word-spaced registers, zero wait states, read back zero-extended.
// ----------------------------------------------------------------------------
module pidf_cfg_regs import pidf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint        <= '0;
            r_cfg.prop_gain       <= '0;
            r_cfg.integral_gain   <= '0;
            r_cfg.derivative_gain <= '0;
            r_cfg.out_min         <= '0;
            r_cfg.out_max         <= RST_OUT_MAX;
            r_cfg.windup_limit    <= RST_WINDUP;
            r_cfg.filter_alphas   <= RST_ALPHAS;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SETPOINT:        r_cfg.setpoint        <= pwdata[PV_W-1:0];
                REG_PROP_GAIN:       r_cfg.prop_gain       <= pwdata[GAIN_W-1:0];
                REG_INTEGRAL_GAIN:   r_cfg.integral_gain   <= pwdata[GAIN_W-1:0];
                REG_DERIVATIVE_GAIN: r_cfg.derivative_gain <= pwdata[GAIN_W-1:0];
                REG_OUT_MIN:         r_cfg.out_min         <= pwdata[PV_W-1:0];
                REG_OUT_MAX:         r_cfg.out_max         <= pwdata[PV_W-1:0];
                REG_WINDUP_LIMIT:    r_cfg.windup_limit    <= pwdata[LIM_W-1:0];
                REG_FILTER_ALPHAS:   r_cfg.filter_alphas   <= pwdata[ALPHAS_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SETPOINT:        prdata = {{(CFG_DW-PV_W){1'b0}}, r_cfg.setpoint};
            REG_PROP_GAIN:       prdata = {{(CFG_DW-GAIN_W){1'b0}}, r_cfg.prop_gain};
            REG_INTEGRAL_GAIN:   prdata = {{(CFG_DW-GAIN_W){1'b0}}, r_cfg.integral_gain};
            REG_DERIVATIVE_GAIN: prdata = {{(CFG_DW-GAIN_W){1'b0}}, r_cfg.derivative_gain};
            REG_OUT_MIN:         prdata = {{(CFG_DW-PV_W){1'b0}}, r_cfg.out_min};
            REG_OUT_MAX:         prdata = {{(CFG_DW-PV_W){1'b0}}, r_cfg.out_max};
            REG_WINDUP_LIMIT:    prdata = {{(CFG_DW-LIM_W){1'b0}}, r_cfg.windup_limit};
            REG_FILTER_ALPHAS:   prdata = {{(CFG_DW-ALPHAS_W){1'b0}}, r_cfg.filter_alphas};
        endcase
    end

endmodule

@@ rtl/pidf_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidf_mac: shared multiply-accumulate unit
// 24x32 signed product registered, then summed into a 58-bit accumulator.
// ----------------------------------------------------------------------------
module pidf_mac import pidf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_cmd                i_cmd,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]         r_bias;
    logic                     r_first;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;

    assign n_prod = i_cmd.a * i_cmd.b;
    assign o_acc  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= i_cmd.en;
            if (i_cmd.en) begin
                r_prod  <= n_prod;
                r_first <= i_cmd.first;
                r_bias  <= i_cmd.bias;
            end
            // first product of a sum starts from the rounding bias
            if (r_pv) begin
                r_acc <= (r_first ? $signed(r_bias) : r_acc)
                       + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            end
        end
    end

endmodule

@@ rtl/pid_step_with_filters_antiwindup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_step_with_filters_antiwindup: PID step with EMA filters and anti-windup
// Sequencer driving one shared multiply-accumulate unit per sample item.
// ----------------------------------------------------------------------------
//  port    dir  handshake      carries
//  i_in    in   valid/ready    operation, measured_value
//  o_out   out  valid/ready    drive, error_value, integral_limited
//  APB     in   psel/penable   register writes and reads, pready tied high
//
//  A hold item goes from idle straight to the result state. A sample runs the
//  error, integral and gain steps, with the input and output filter steps added
//  when those filters are on; every product goes through the single 24x32
//  multiplier and its accumulate stage, and the pipe drains before each result is used.
//  Synchronous active-low reset idles the sequencer and clears filter and integral state.
//  The input is taken only when the sequencer is idle; a finished result sits
//  in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module pid_step_with_filters_antiwindup import pidf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pidf_in_if.sink           i_in,
    pidf_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [4:0] {
        S_IDLE, S_IF_A, S_IF_B, S_IF_W, S_ERR, S_INT_M, S_INT_W, S_INT_ADD,
        S_P_M, S_I_M, S_D_M, S_D_W, S_CLAMP, S_OF_A, S_OF_B, S_OF_W,
        S_OF_DONE, S_FIN
    } t_state;

    t_cfg                    w_cfg;
    t_mac_cmd                w_cmd;
    logic signed [ACC_W-1:0] w_acc;

    t_state                  r_state, n_state;
    logic signed [PV_W-1:0]  r_x, n_x;
    logic signed [PV_W-1:0]  r_ifv, n_ifv;
    logic signed [PV_W-1:0]  r_ofv, n_ofv;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic signed [ERR_W-1:0] r_prev, n_prev;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic signed [DER_W-1:0] r_deriv, n_deriv;
    logic signed [PV_W-1:0]  r_drive, n_drive;
    logic                    r_lim, n_lim;
    logic                    r_out_valid, n_out_valid;
    logic [PV_W-1:0]         r_out_drive, n_out_drive;
    logic [ERR_W-1:0]        r_out_err, n_out_err;
    logic                    r_out_lim, n_out_lim;

    logic [ALPHA_W-1:0]      w_a_in, w_a_out;
    logic [ALPHA_W:0]        w_wt_in, w_wt_out;
    logic                    w_in_on, w_out_on;
    logic signed [PV_W-1:0]  w_ema;
    logic signed [PV_W-1:0]  w_xf;
    logic signed [STEP_W-1:0] w_step;
    logic signed [SUM_W:0]   w_sum_add;
    logic signed [SUM_W-1:0] w_sum_sat;
    logic signed [DRV_W-1:0] w_drv, w_lo, w_hi;
    logic signed [SUM_W:0]   w_sum33, w_lim33, w_nlim33;

    pidf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pidf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_acc   (w_acc)
    );

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.drive            = r_out_drive;
    assign o_out.error_value      = r_out_err;
    assign o_out.integral_limited = r_out_lim;

    // alphas below 0.01 are raised; 1.0 and above bypass the filter
    assign w_a_in   = (w_cfg.filter_alphas[ALPHA_W-1:0] < ALPHA_MIN) ? ALPHA_MIN
                    : w_cfg.filter_alphas[ALPHA_W-1:0];
    assign w_a_out  = (w_cfg.filter_alphas[ALPHAS_W-1:ALPHA_W] < ALPHA_MIN) ? ALPHA_MIN
                    : w_cfg.filter_alphas[ALPHAS_W-1:ALPHA_W];
    assign w_in_on  = !w_a_in[ALPHA_W-1];
    assign w_out_on = !w_a_out[ALPHA_W-1];
    assign w_wt_in  = ALPHA_ONE - {1'b0, w_a_in};
    assign w_wt_out = ALPHA_ONE - {1'b0, w_a_out};

    assign w_ema  = w_acc[PV_W+7:8];
    assign w_xf   = w_in_on ? w_ema : r_x;
    assign w_step = w_acc[STEP_W+14:15];

    assign w_sum_add = {r_sum[SUM_W-1], r_sum} + {{(SUM_W+1-STEP_W){w_step[STEP_W-1]}}, w_step};
    always_comb begin
        if (w_sum_add[SUM_W] != w_sum_add[SUM_W-1]) begin
            w_sum_sat = w_sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_sum_sat = w_sum_add[SUM_W-1:0];
        end
    end

    assign w_drv    = w_acc[ACC_W-1:12];
    assign w_lo     = {{(DRV_W-PV_W){w_cfg.out_min[PV_W-1]}}, w_cfg.out_min};
    assign w_hi     = {{(DRV_W-PV_W){w_cfg.out_max[PV_W-1]}}, w_cfg.out_max};
    assign w_sum33  = {r_sum[SUM_W-1], r_sum};
    assign w_lim33  = {2'b00, w_cfg.windup_limit};
    assign w_nlim33 = -w_lim33;

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_ifv       = r_ifv;
        n_ofv       = r_ofv;
        n_sum       = r_sum;
        n_prev      = r_prev;
        n_err       = r_err;
        n_deriv     = r_deriv;
        n_drive     = r_drive;
        n_lim       = r_lim;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_drive = r_out_drive;
        n_out_err   = r_out_err;
        n_out_lim   = r_out_lim;

        w_cmd       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_x = i_in.measured_value;
                    if (i_in.operation == OP_HOLD) begin
                        n_sum   = '0;
                        n_prev  = '0;
                        n_drive = '0;
                        n_err   = '0;
                        n_lim   = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_state = w_in_on ? S_IF_A : S_ERR;
                    end
                end
            end
            S_IF_A: begin
                w_cmd.en    = 1'b1;
                w_cmd.first = 1'b1;
                w_cmd.bias  = BIAS_EMA;
                w_cmd.a     = {{(MUL_A_W-ALPHA_W){1'b0}}, w_a_in};
                w_cmd.b     = {{(MUL_B_W-PV_W){r_x[PV_W-1]}}, r_x};
                n_state     = S_IF_B;
            end
            S_IF_B: begin
                w_cmd.en = 1'b1;
                w_cmd.a  = {{(MUL_A_W-ALPHA_W-1){1'b0}}, w_wt_in};
                w_cmd.b  = {{(MUL_B_W-PV_W){r_ifv[PV_W-1]}}, r_ifv};
                n_state  = S_IF_W;
            end
            S_IF_W: n_state = S_ERR;
            S_ERR: begin
                if (w_in_on) begin
                    n_ifv = w_ema;
                end
                n_err   = {w_cfg.setpoint[PV_W-1], w_cfg.setpoint} - {w_xf[PV_W-1], w_xf};
                n_state = S_INT_M;
            end
            S_INT_M: begin
                w_cmd.en    = 1'b1;
                w_cmd.first = 1'b1;
                w_cmd.bias  = BIAS_INT;
                w_cmd.a     = {{(MUL_A_W-13){1'b0}}, TENTH_Q15};
                w_cmd.b     = {{(MUL_B_W-ERR_W){r_err[ERR_W-1]}}, r_err};
                n_deriv     = {r_err[ERR_W-1], r_err} - {r_prev[ERR_W-1], r_prev};
                n_state     = S_INT_W;
            end
            S_INT_W: n_state = S_INT_ADD;
            S_INT_ADD: begin
                // a zero error clears the integral instead of accumulating
                n_sum   = (r_err == '0) ? '0 : w_sum_sat;
                n_state = S_P_M;
            end
            S_P_M: begin
                w_cmd.en    = 1'b1;
                w_cmd.first = 1'b1;
                w_cmd.bias  = BIAS_DRV;
                w_cmd.a     = w_cfg.prop_gain;
                w_cmd.b     = {{(MUL_B_W-ERR_W){r_err[ERR_W-1]}}, r_err};
                n_state     = S_I_M;
            end
            S_I_M: begin
                w_cmd.en = 1'b1;
                w_cmd.a  = w_cfg.integral_gain;
                w_cmd.b  = r_sum;
                n_state  = S_D_M;
            end
            S_D_M: begin
                w_cmd.en = 1'b1;
                w_cmd.a  = w_cfg.derivative_gain;
                w_cmd.b  = {{(MUL_B_W-DER_W){r_deriv[DER_W-1]}}, r_deriv};
                n_state  = S_D_W;
            end
            S_D_W: n_state = S_CLAMP;
            S_CLAMP: begin
                if (w_drv < w_lo) begin
                    n_drive = w_cfg.out_min;
                end else if (w_drv > w_hi) begin
                    n_drive = w_cfg.out_max;
                end else begin
                    n_drive = w_drv[PV_W-1:0];
                end
                // windup limit applies after the drive has used the raw sum
                n_lim = 1'b0;
                if (w_sum33 > w_lim33) begin
                    n_sum = w_lim33[SUM_W-1:0];
                    n_lim = 1'b1;
                end else if (w_sum33 < w_nlim33) begin
                    n_sum = w_nlim33[SUM_W-1:0];
                    n_lim = 1'b1;
                end
                n_prev  = r_err;
                n_state = w_out_on ? S_OF_A : S_FIN;
            end
            S_OF_A: begin
                w_cmd.en    = 1'b1;
                w_cmd.first = 1'b1;
                w_cmd.bias  = BIAS_EMA;
                w_cmd.a     = {{(MUL_A_W-ALPHA_W){1'b0}}, w_a_out};
                w_cmd.b     = {{(MUL_B_W-PV_W){r_drive[PV_W-1]}}, r_drive};
                n_state     = S_OF_B;
            end
            S_OF_B: begin
                w_cmd.en = 1'b1;
                w_cmd.a  = {{(MUL_A_W-ALPHA_W-1){1'b0}}, w_wt_out};
                w_cmd.b  = {{(MUL_B_W-PV_W){r_ofv[PV_W-1]}}, r_ofv};
                n_state  = S_OF_W;
            end
            S_OF_W: n_state = S_OF_DONE;
            S_OF_DONE: begin
                n_ofv   = w_ema;
                n_drive = w_ema;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_drive = r_drive;
                    n_out_err   = r_err;
                    n_out_lim   = r_lim;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ifv       <= '0;
            r_ofv       <= '0;
            r_sum       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ifv       <= n_ifv;
            r_ofv       <= n_ofv;
            r_sum       <= n_sum;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
        r_x         <= n_x;
        r_err       <= n_err;
        r_deriv     <= n_deriv;
        r_drive     <= n_drive;
        r_lim       <= n_lim;
        r_out_drive <= n_out_drive;
        r_out_err   <= n_out_err;
        r_out_lim   <= n_out_lim;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the PID step with filters and anti-windup
// Registers are written over APB between runs of sample and hold items. Each
// item goes through a cycle-free model of the control law, and the result
// items are compared field by field, in order. A short table of directed rows
// comes first, then randomised phases with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import pidf_pkg::*;

    localparam int     CLK_HALF        = 5;
    localparam int     CYCLE_LIMIT     = 400000;
    localparam int     N_PHASES        = 14;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam longint SUM_MAX         = (longint'(1) <<< 31) - 1;
    localparam longint SUM_MIN         = -(longint'(1) <<< 31);

    typedef struct packed {
        logic [PV_W-1:0]  drive;
        logic [ERR_W-1:0] error_value;
        logic             integral_limited;
    } t_pid_result;

    typedef struct {
        bit                is_cfg;
        t_reg_idx          reg_idx;
        logic [CFG_DW-1:0] value;
        logic              op;
        logic [PV_W-1:0]   meas;
        bit                typed;
        t_pid_result       want;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    pidf_in_if  in_ch ();
    pidf_out_if out_ch ();

    pid_step_with_filters_antiwindup DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // controller copy: registers and loop state
    t_cfg        cfg_shadow;
    longint      in_filt;
    longint      out_filt;
    longint      integ_sum;
    longint      prev_err;

    t_pid_result pending_results[$];
    t_stim_row   stim_table[$];
    int          fail_count     = 0;
    bit          no_idle        = 1'b0;
    bit          hold_off_req   = 1'b0;
    bit          hold_off_taken = 1'b0;
    int          stall_left     = 0;
    int          cycle_cnt      = 0;

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    function automatic longint ema_step(longint x, longint old, longint a);
        return (a * x + (longint'(ALPHA_ONE) - a) * old + 128) >>> 8;
    endfunction

    function automatic longint alpha_of(logic [ALPHA_W-1:0] raw);
        return (raw < ALPHA_MIN) ? longint'(ALPHA_MIN) : longint'(raw);
    endfunction

    function automatic t_pid_result pid_predict(logic op, logic [PV_W-1:0] meas);
        longint      a_in, a_out, x, err, deriv, acc, drv, lo, hi, lim;
        t_pid_result r;
        a_in  = alpha_of(cfg_shadow.filter_alphas[ALPHA_W-1:0]);
        a_out = alpha_of(cfg_shadow.filter_alphas[ALPHAS_W-1:ALPHA_W]);
        r = '0;
        if (op == OP_HOLD) begin
            integ_sum = 0;
            prev_err  = 0;
            return r;
        end
        x = longint'($signed(meas));
        if (a_in < longint'(ALPHA_ONE)) begin
            in_filt = ema_step(x, in_filt, a_in);
            x = in_filt;
        end
        err = longint'($signed(cfg_shadow.setpoint)) - x;
        // zero error wipes the integral instead of accumulating
        if (err == 0) begin
            integ_sum = 0;
        end else begin
            integ_sum += (err * longint'(TENTH_Q15) + 16384) >>> 15;
            if (integ_sum > SUM_MAX) integ_sum = SUM_MAX;
            if (integ_sum < SUM_MIN) integ_sum = SUM_MIN;
        end
        deriv = err - prev_err;
        acc = longint'($signed(cfg_shadow.prop_gain)) * err
            + longint'($signed(cfg_shadow.integral_gain)) * integ_sum
            + longint'($signed(cfg_shadow.derivative_gain)) * deriv;
        drv = (acc + 2048) >>> 12;
        lo  = longint'($signed(cfg_shadow.out_min));
        hi  = longint'($signed(cfg_shadow.out_max));
        if (drv < lo) drv = lo;
        else if (drv > hi) drv = hi;
        // windup limit applies after the drive is formed
        lim = longint'(cfg_shadow.windup_limit);
        if (integ_sum > lim) begin
            integ_sum = lim;
            r.integral_limited = 1'b1;
        end else if (integ_sum < -lim) begin
            integ_sum = -lim;
            r.integral_limited = 1'b1;
        end
        prev_err = err;
        if (a_out < longint'(ALPHA_ONE)) begin
            out_filt = ema_step(drv, out_filt, a_out);
            drv = out_filt;
        end
        r.drive       = drv[PV_W-1:0];
        r.error_value = err[ERR_W-1:0];
        return r;
    endfunction

    function automatic void add_cfg(t_reg_idx idx, logic [CFG_DW-1:0] val);
        t_stim_row row;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = val;
        row.op      = OP_SAMPLE;
        row.meas    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        stim_table.push_back(row);
    endfunction

    function automatic void add_item(logic op, logic [PV_W-1:0] meas, bit typed,
                                     t_pid_result want);
        t_stim_row row;
        row.is_cfg  = 1'b0;
        row.reg_idx = REG_SETPOINT;
        row.value   = '0;
        row.op      = op;
        row.meas    = meas;
        row.typed   = typed;
        row.want    = want;
        stim_table.push_back(row);
    endfunction

    function automatic logic [ALPHA_W-1:0] rand_alpha();
        case ($urandom_range(5))
            0:       return 9'($urandom_range(256, 511));
            1:       return 9'($urandom_range(0, 2));
            2:       return 9'd256;
            default: return 9'($urandom_range(3, 255));
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] rand_reg_value(t_reg_idx idx);
        logic [CFG_DW-1:0] v;
        int                pick;
        pick = $urandom_range(7);
        case (idx)
            REG_SETPOINT:
                v = (pick == 0) ? 32'h7FFF : (pick == 1) ? 32'h8000 :
                    (pick == 2) ? $urandom : 32'($urandom_range(0, 'h2000)) - 32'h1000;
            REG_PROP_GAIN, REG_DERIVATIVE_GAIN:
                v = (pick == 0) ? 32'h7F_FFFF : (pick == 1) ? 32'h80_0000 :
                    (pick == 2) ? $urandom : 32'($urandom_range(0, 'h6000)) - 32'h3000;
            REG_INTEGRAL_GAIN:
                v = (pick == 0) ? 32'h7F_FFFF : (pick == 1) ? 32'h80_0000 :
                    (pick == 2) ? $urandom : 32'($urandom_range(0, 'h800)) - 32'h400;
            REG_OUT_MIN:
                v = (pick == 0) ? 32'h8000 : (pick == 1) ? 32'h7FFF :
                    (pick == 2) ? $urandom : -32'($urandom_range(0, 'h6000));
            REG_OUT_MAX:
                v = (pick == 0) ? 32'h7FFF : (pick == 1) ? 32'h8000 :
                    (pick == 2) ? $urandom : 32'($urandom_range(0, 'h6000));
            REG_WINDUP_LIMIT:
                v = (pick == 0) ? 32'h7FFF_FFFF : (pick == 1) ? 32'h0 :
                    (pick == 2) ? $urandom : 32'($urandom_range(0, 'h2_0000));
            default:
                v = {14'd0, rand_alpha(), rand_alpha()};
        endcase
        return v;
    endfunction

    function automatic logic [PV_W-1:0] random_measure();
        logic [PV_W-1:0] sp;
        sp = cfg_shadow.setpoint;
        case ($urandom_range(7))
            0:       return sp;
            1, 2:    return 16'($urandom);
            3:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return sp + 16'($urandom_range(0, 'h400)) - 16'h200;
        endcase
    endfunction

    task automatic cfg_write(t_reg_idx idx, logic [CFG_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SETPOINT:        cfg_shadow.setpoint        = val[PV_W-1:0];
            REG_PROP_GAIN:       cfg_shadow.prop_gain       = val[GAIN_W-1:0];
            REG_INTEGRAL_GAIN:   cfg_shadow.integral_gain   = val[GAIN_W-1:0];
            REG_DERIVATIVE_GAIN: cfg_shadow.derivative_gain = val[GAIN_W-1:0];
            REG_OUT_MIN:         cfg_shadow.out_min         = val[PV_W-1:0];
            REG_OUT_MAX:         cfg_shadow.out_max         = val[PV_W-1:0];
            REG_WINDUP_LIMIT:    cfg_shadow.windup_limit    = val[LIM_W-1:0];
            default:             cfg_shadow.filter_alphas   = val[ALPHAS_W-1:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_item(logic op, logic [PV_W-1:0] meas, bit typed, t_pid_result want);
        t_pid_result predicted;
        while (!no_idle && $urandom_range(99) < 9) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= op;
        in_ch.measured_value <= meas;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predicted = pid_predict(op, meas);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // stop offering and let every outstanding item drain
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_result();
        t_pid_result want;
        if (pending_results.size() == 0) begin
            $error("result item with nothing expected");
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        if (out_ch.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", $signed(want.drive), $signed(out_ch.drive));
            fail_count++;
        end
        if (out_ch.error_value !== want.error_value) begin
            $error("error_value: expected %0d, got %0d",
                   $signed(want.error_value), $signed(out_ch.error_value));
            fail_count++;
        end
        if (out_ch.integral_limited !== want.integral_limited) begin
            $error("integral_limited: expected %0d, got %0d",
                   want.integral_limited, out_ch.integral_limited);
            fail_count++;
        end
    endtask

    // result side: check, then choose ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) check_result();
        if (hold_off_req && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            stall_left     = HOLD_OFF_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= no_idle || ($urandom_range(99) >= 9);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int   n_items;
        logic op;
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.operation      <= OP_SAMPLE;
        in_ch.measured_value <= '0;

        cfg_shadow.setpoint        = '0;
        cfg_shadow.prop_gain       = '0;
        cfg_shadow.integral_gain   = '0;
        cfg_shadow.derivative_gain = '0;
        cfg_shadow.out_min         = '0;
        cfg_shadow.out_max         = RST_OUT_MAX;
        cfg_shadow.windup_limit    = RST_WINDUP;
        cfg_shadow.filter_alphas   = RST_ALPHAS;
        in_filt   = 0;
        out_filt  = 0;
        integ_sum = 0;
        prev_err  = 0;

        // reset values: zero gains, filters off
        add_item(OP_SAMPLE, 16'h0000, 1'b1, {16'h0000, 17'h00000, 1'b0});
        add_item(OP_SAMPLE, 16'h8000, 1'b1, {16'h0000, 17'h08000, 1'b0});
        add_item(OP_SAMPLE, 16'h7FFF, 1'b1, {16'h0000, 17'h18001, 1'b0});
        add_item(OP_HOLD,   16'h1234, 1'b1, {16'h0000, 17'h00000, 1'b0});
        add_cfg(REG_SETPOINT, 32'h0100);
        add_cfg(REG_PROP_GAIN, 32'h00_1000);
        add_cfg(REG_INTEGRAL_GAIN, 32'h00_0200);
        add_cfg(REG_DERIVATIVE_GAIN, 32'h00_0800);
        add_cfg(REG_OUT_MIN, 32'h9C00);
        add_cfg(REG_OUT_MAX, 32'h6400);
        add_item(OP_SAMPLE, 16'h0100, 1'b0, '0);
        add_item(OP_SAMPLE, 16'h0000, 1'b0, '0);
        add_item(OP_SAMPLE, 16'h0080, 1'b0, '0);
        add_item(OP_SAMPLE, 16'h0180, 1'b0, '0);
        add_cfg(REG_WINDUP_LIMIT, 32'h40);
        add_item(OP_SAMPLE, 16'h8000, 1'b0, '0);
        add_item(OP_SAMPLE, 16'h8000, 1'b0, '0);
        add_item(OP_SAMPLE, 16'h7FFF, 1'b0, '0);
        add_cfg(REG_WINDUP_LIMIT, 32'h0);
        add_item(OP_SAMPLE, 16'h0200, 1'b0, '0);
        // alphas below the floor on both filters
        add_cfg(REG_FILTER_ALPHAS, {14'd0, 9'd1, 9'd0});
        add_item(OP_SAMPLE, 16'h7FFF, 1'b0, '0);
        add_item(OP_SAMPLE, 16'h8000, 1'b0, '0);
        add_cfg(REG_FILTER_ALPHAS, {14'd0, 9'd511, 9'd128});
        add_item(OP_SAMPLE, 16'h4000, 1'b0, '0);
        add_item(OP_HOLD,   16'h0000, 1'b0, '0);
        // crossed clamp limits
        add_cfg(REG_OUT_MIN, 32'h7FFF);
        add_cfg(REG_OUT_MAX, 32'h8000);
        add_item(OP_SAMPLE, 16'h1000, 1'b0, '0);
        add_cfg(REG_WINDUP_LIMIT, 32'h7FFF_FFFF);
        add_cfg(REG_PROP_GAIN, 32'h7F_FFFF);
        add_cfg(REG_INTEGRAL_GAIN, 32'h80_0000);
        add_cfg(REG_DERIVATIVE_GAIN, 32'h7F_FFFF);
        add_cfg(REG_OUT_MIN, 32'h8000);
        add_cfg(REG_OUT_MAX, 32'h7FFF);
        add_cfg(REG_FILTER_ALPHAS, {14'd0, 9'd256, 9'd256});
        add_cfg(REG_SETPOINT, 32'h7FFF);
        add_item(OP_SAMPLE, 16'h8000, 1'b0, '0);
        add_item(OP_SAMPLE, 16'h8000, 1'b0, '0);
        add_cfg(REG_SETPOINT, 32'h8000);
        add_item(OP_SAMPLE, 16'h7FFF, 1'b0, '0);
        add_item(OP_SAMPLE, 16'h7FFF, 1'b0, '0);
        add_item(OP_HOLD,   16'hFFFF, 1'b1, {16'h0000, 17'h00000, 1'b0});
        add_item(OP_SAMPLE, 16'h8000, 1'b0, '0);
        add_cfg(REG_PROP_GAIN, 32'h80_0000);
        add_item(OP_SAMPLE, 16'h0000, 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[k]) begin
            if (stim_table[k].is_cfg) begin
                wait_idle();
                cfg_write(stim_table[k].reg_idx, stim_table[k].value);
            end else begin
                send_item(stim_table[k].op, stim_table[k].meas, stim_table[k].typed,
                          stim_table[k].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            for (int ri = 0; ri < 8; ri++) cfg_write(t_reg_idx'(ri), rand_reg_value(t_reg_idx'(ri)));
            no_idle = (ph == 3);
            // long receiver stall while items keep coming
            if (ph == 5) hold_off_req = 1'b1;
            n_items = $urandom_range(110, 180);
            for (int k = 0; k < n_items; k++) begin
                if (ph == 8 && k == n_items / 2) wait_idle();
                op = ($urandom_range(19) == 0) ? OP_HOLD : OP_SAMPLE;
                send_item(op, random_measure(), 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
